>>> sv/csm_pkg.sv
// Package for the compressed-row sparse matrix-vector engine.
// Holds sizes, action codes and the input and result transfer structs; no dependencies.
package csm_pkg;
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int NZ_DEPTH = 1024;
	localparam int NZ_W = $clog2(NZ_DEPTH);

	typedef enum logic [2:0] {
		ACT_ROW_PTR = 3'd0,
		ACT_NONZERO = 3'd1,
		ACT_VECTOR  = 3'd2,
		ACT_RUN_AX  = 3'd3,
		ACT_RUN_ATX = 3'd4
	} action_t;

	localparam logic CFG_ROW_COUNT = 1'b0;
	localparam logic CFG_COL_COUNT = 1'b1;

	typedef struct packed {
		logic [2:0]         action;
		logic [9:0]         slot;
		logic [10:0]        row_start;
		logic [5:0]         column;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic [5:0]         out_index;
		logic signed [31:0] out_value;
		logic               saturated;
		logic               last;
	} result_t;
endpackage

>>> sv/csr_sparse_matvec.sv
// Top level of the compressed-row sparse matrix-vector engine.
// Uses csm_pkg; all stores are local synchronous memories.
//
// Load items (row pointer, nonzero entry, vector element) are written straight
// into the stores while idle, so busy never rises for them. A run holds busy
// high while it walks the stores: for A*x each row takes two pointer reads, a
// span check and the result, with a vector read, multiply and accumulate per
// nonzero, and a last row check ends the run; A^T*x first clears 64 column
// accumulators, then walks the rows the same way with a read-modify-write of
// the accumulator memory per nonzero, then streams out the columns, each with
// a bound check and an output step, then a closing check. The receiver cannot
// stall: each result appears for one cycle with result_valid high, in index
// order, the last one marked.
module csr_sparse_matvec (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  csm_pkg::item_t   item,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [6:0]       cfg_data,
	output logic             result_valid,
	output csm_pkg::result_t result
);
	import csm_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_CLR   = 11'b00000000010,
		ST_RP0   = 11'b00000000100,
		ST_RP1   = 11'b00000001000,
		ST_RD    = 11'b00000010000,
		ST_MUL   = 11'b00000100000,
		ST_ACC   = 11'b00001000000,
		ST_ROWND = 11'b00010000000,
		ST_ORD   = 11'b00100000000,
		ST_OUT   = 11'b01000000000,
		ST_VEC   = 11'b10000000000
	} state_t;

	logic [10:0]        rp_mem [MAX_ROWS+1];
	logic [5:0]         col_mem [NZ_DEPTH];
	logic signed [31:0] val_mem [NZ_DEPTH];
	logic signed [31:0] vec_mem [64];
	logic signed [63:0] acc_mem [MAX_COLS];
	logic               csat_mem [MAX_COLS];

	state_t             state_q;
	logic               trans_q;
	logic [6:0]         row_count_q, col_count_q, rows_q, cols_q;
	logic [6:0]         r_q, c_q;
	logic [10:0]        j_q, jend_q, rp_rd_q;
	logic [6:0]         rp_addr;
	logic [5:0]         col_rd_q;
	logic signed [31:0] val_rd_q, vec_rd_q;
	logic signed [63:0] prod_q, acc_q, am_rd_q;
	logic               sat_q, cs_rd_q, cvalid_q;
	logic [5:0]         pcol_q;
	logic               rv_q;
	result_t            res_q;

	logic accept;
	logic signed [63:0] base, sum;
	logic               bsat, ovf, nsat;
	logic signed [63:0] sres;
	logic signed [47:0] q;
	logic               qs;
	logic [5:0]         vaddr;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign result_valid = rv_q;
	assign result = res_q;

	// Memory writes and registered reads.
	always_ff @(posedge clk) begin
		if (accept && item.action == ACT_ROW_PTR && item.slot <= 10'(MAX_ROWS))
			rp_mem[item.slot[6:0]] <= item.row_start;
		if (accept && item.action == ACT_NONZERO) begin
			col_mem[item.slot[NZ_W-1:0]] <= item.column;
			val_mem[item.slot[NZ_W-1:0]] <= item.value;
		end
		if (accept && item.action == ACT_VECTOR && item.slot < 10'd64)
			vec_mem[item.slot[5:0]] <= item.value;
		rp_rd_q  <= rp_mem[rp_addr];
		col_rd_q <= col_mem[j_q[NZ_W-1:0]];
		val_rd_q <= val_mem[j_q[NZ_W-1:0]];
		vec_rd_q <= vec_mem[vaddr];
		if (state_q == ST_CLR) begin
			acc_mem[c_q[5:0]]  <= '0;
			csat_mem[c_q[5:0]] <= 1'b0;
		end else if (state_q == ST_ACC && trans_q && cvalid_q) begin
			acc_mem[pcol_q]  <= sum;
			csat_mem[pcol_q] <= nsat;
		end
		am_rd_q <= acc_mem[state_q == ST_ORD ? c_q[5:0] : col_rd_q];
		cs_rd_q <= csat_mem[state_q == ST_ORD ? c_q[5:0] : col_rd_q];
	end

	always_comb begin
		rp_addr = (state_q == ST_RP0) ? r_q : r_q + 7'd1;
		vaddr = trans_q ? r_q[5:0] : col_rd_q;
	end

	// Saturating add of the product to the row or column accumulator.
	always_comb begin
		base = trans_q ? am_rd_q : acc_q;
		bsat = trans_q ? cs_rd_q : sat_q;
		sum = base + prod_q;
		ovf = (base[63] == prod_q[63]) && (sum[63] != base[63]);
		if (ovf)
			sum = base[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		nsat = bsat | ovf;
	end

	// Floor shift back to Q16.16 and clip to 32 bits.
	always_comb begin
		sres = trans_q ? am_rd_q : acc_q;
		qs = trans_q ? cs_rd_q : sat_q;
		q = sres[63:16];
		if (q > 48'sd2147483647) begin
			q = 48'sd2147483647;
			qs = 1'b1;
		end else if (q < -48'sd2147483648) begin
			q = -48'sd2147483648;
			qs = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_count_q <= '0;
			col_count_q <= '0;
			rv_q <= 1'b0;
		end else begin
			rv_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_ROW_COUNT) row_count_q <= cfg_data;
				else col_count_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					rows_q <= (row_count_q > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : row_count_q;
					cols_q <= (col_count_q > 7'(MAX_COLS)) ? 7'(MAX_COLS) : col_count_q;
					r_q <= '0;
					c_q <= '0;
					if (accept && item.action == ACT_RUN_AX) begin
						trans_q <= 1'b0;
						state_q <= ST_RP0;
					end else if (accept && item.action == ACT_RUN_ATX) begin
						trans_q <= 1'b1;
						state_q <= ST_CLR;
					end
				end
				ST_CLR: begin
					c_q <= c_q + 7'd1;
					if (c_q == 7'(MAX_COLS - 1)) begin
						c_q <= '0;
						state_q <= ST_RP0;
					end
				end
				ST_RP0: begin
					if (r_q >= rows_q) begin
						state_q <= trans_q ? ST_ORD : ST_IDLE;
					end else state_q <= ST_RP1;
				end
				ST_RP1: begin
					j_q <= rp_rd_q;
					acc_q <= '0;
					sat_q <= 1'b0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					jend_q <= rp_rd_q;
					if (j_q < rp_rd_q && j_q < 11'(NZ_DEPTH)) state_q <= ST_VEC;
					else state_q <= ST_ROWND;
				end
				ST_VEC: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q <= 64'(val_rd_q) * 64'(vec_rd_q);
					pcol_q <= col_rd_q;
					cvalid_q <= {1'b0, col_rd_q} < cols_q;
					j_q <= j_q + 11'd1;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (!trans_q) begin
						acc_q <= sum;
						sat_q <= nsat;
					end
					if (j_q < jend_q && j_q < 11'(NZ_DEPTH)) state_q <= ST_VEC;
					else state_q <= ST_ROWND;
				end
				ST_ROWND: begin
					if (!trans_q) begin
						rv_q <= 1'b1;
						res_q <= '{out_index: r_q[5:0], out_value: q[31:0],
							saturated: qs, last: (r_q + 7'd1 == rows_q)};
					end
					r_q <= r_q + 7'd1;
					state_q <= ST_RP0;
				end
				ST_ORD: begin
					if (c_q >= cols_q) state_q <= ST_IDLE;
					else state_q <= ST_OUT;
				end
				ST_OUT: begin
					rv_q <= 1'b1;
					res_q <= '{out_index: c_q[5:0], out_value: q[31:0],
						saturated: qs, last: (c_q + 7'd1 == cols_q)};
					c_q <= c_q + 7'd1;
					state_q <= ST_ORD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
